[hw/rtl/mba_pkg.sv]
// Shared types, constants and register codes of the multichannel block averager.
package mba_pkg;

    localparam int LANES       = 4;
    localparam int LANE_W      = 2;
    localparam int CHAN_W      = 3;
    localparam int VALUE_W     = 12;
    localparam int AVG_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int SAMPLES_DEF = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_VALUE   = 4095;

    localparam logic [AVG_W-1:0] CENTER = 12'd2048;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LANE0_CHANNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE1_CHANNEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE2_CHANNEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE3_CHANNEL = 3'd3;

    typedef struct packed {
        logic [CHAN_W-1:0]  sample_channel;
        logic [VALUE_W-1:0] sample_value;
    } t_in;

    typedef struct packed {
        logic [LANE_W-1:0]       lane_index;
        logic signed [AVG_W-1:0] centered_average;
    } t_out;

    // A classified sample as it waits between the front and the back.
    typedef struct packed {
        logic [LANE_W-1:0]  lane;
        logic [VALUE_W-1:0] value;
    } t_item;

endpackage

[hw/rtl/mba_front.sv]
// Front part: holds the lane channel registers and routes each sample whose channel matches a lane to that lane.
module mba_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mba_pkg::t_in                     i_in_data,
    output logic                             o_push,
    output mba_pkg::t_item                   o_push_item,
    input  logic                             i_queue_full
);

    logic [mba_pkg::CHAN_W-1:0] r_lane_chan [mba_pkg::LANES];
    logic                       hit;
    logic [mba_pkg::LANE_W-1:0] hit_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mba_pkg::LANES; i++) begin
                r_lane_chan[i] <= mba_pkg::CHAN_W'(i);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mba_pkg::CFG_LANE0_CHANNEL: r_lane_chan[0] <= i_cfg_data;
                mba_pkg::CFG_LANE1_CHANNEL: r_lane_chan[1] <= i_cfg_data;
                mba_pkg::CFG_LANE2_CHANNEL: r_lane_chan[2] <= i_cfg_data;
                mba_pkg::CFG_LANE3_CHANNEL: r_lane_chan[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Scan from the top lane down so that the lowest matching lane wins.
    always_comb begin
        hit      = 1'b0;
        hit_lane = '0;
        for (int i = mba_pkg::LANES - 1; i >= 0; i--) begin
            if (r_lane_chan[i] == i_in_data.sample_channel) begin
                hit      = 1'b1;
                hit_lane = mba_pkg::LANE_W'(i);
            end
        end
    end

    assign o_in_stall        = i_queue_full;
    assign o_push            = i_in_valid && !i_queue_full && hit;
    assign o_push_item.lane  = hit_lane;
    assign o_push_item.value = i_in_data.sample_value;

endmodule

[hw/rtl/mba_queue.sv]
// Short queue of classified samples between the front and the back.
module mba_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mba_pkg::t_item  i_push_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mba_pkg::t_item  o_item
);

    localparam int PTR_W = $clog2(mba_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mba_pkg::QUEUE_DEPTH + 1);

    mba_pkg::t_item   r_mem [mba_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(mba_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(mba_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(mba_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/mba_back.sv]
// Back part: per-lane accumulation, block average by reciprocal multiply, output register.
module mba_back #(
    parameter int SAMPLES = mba_pkg::SAMPLES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mba_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output mba_pkg::t_out   o_out_data
);

    localparam int SUM_W = $clog2(SAMPLES * mba_pkg::MAX_VALUE + 1);
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int LOG_S = $clog2(SAMPLES);
    localparam int SHIFT = SUM_W + LOG_S;
    localparam int REC_W = SUM_W + 1;
    localparam int PRD_W = SUM_W + REC_W;
    // floor(sum * RECIP / 2^SHIFT) equals floor(sum / SAMPLES) for every sum below 2^SUM_W.
    localparam logic [REC_W-1:0] RECIP =
        REC_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / SAMPLES);

    logic [SUM_W-1:0] r_sum [mba_pkg::LANES];
    logic [CNT_W-1:0] r_cnt [mba_pkg::LANES];

    logic                       r_s_valid;
    logic [mba_pkg::LANE_W-1:0] r_s_lane;
    logic [SUM_W-1:0]           r_s_sum;
    logic                       r_m_valid;
    logic [mba_pkg::LANE_W-1:0] r_m_lane;
    logic [PRD_W-1:0]           r_m_prod;
    logic                       r_out_valid;
    mba_pkg::t_out              r_out;

    logic                       out_ready;
    logic                       m_ready;
    logic                       s_ready;
    logic [SUM_W-1:0]           acc_sum;
    logic [CNT_W-1:0]           acc_cnt;
    logic                       done;
    logic [mba_pkg::AVG_W-1:0]  avg;

    assign out_ready = !r_out_valid || !i_out_stall;
    assign m_ready   = !r_m_valid || out_ready;
    assign s_ready   = !r_s_valid || m_ready;
    assign o_pop     = i_valid && s_ready;

    assign acc_sum = r_sum[i_item.lane] + SUM_W'(i_item.value);
    assign acc_cnt = r_cnt[i_item.lane] + 1'b1;
    assign done    = (acc_cnt == CNT_W'(SAMPLES));
    assign avg     = r_m_prod[SHIFT +: mba_pkg::AVG_W];

    // Lane accumulators; a completed block clears its lane as the sum moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mba_pkg::LANES; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else if (o_pop) begin
            r_sum[i_item.lane] <= done ? '0 : acc_sum;
            r_cnt[i_item.lane] <= done ? '0 : acc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_ready) begin
                r_s_valid <= o_pop && done;
            end
            if (m_ready) begin
                r_m_valid <= r_s_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready) begin
            r_s_lane <= i_item.lane;
            r_s_sum  <= acc_sum;
        end
        if (m_ready) begin
            r_m_lane <= r_s_lane;
            r_m_prod <= PRD_W'(r_s_sum) * PRD_W'(RECIP);
        end
        if (out_ready) begin
            r_out.lane_index       <= r_m_lane;
            r_out.centered_average <= avg - mba_pkg::CENTER;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/multichannel_block_averager.sv]
// Top level of the four-lane block-average decimator.
//
//  channel  valid         stall         payload       direction
//  input    i_in_valid    o_in_stall    i_in_data     tagged converter samples in
//  output   o_out_valid   i_out_stall   o_out_data    lane index and centered average out
//  config   i_cfg_we      -             i_cfg_index, i_cfg_data   lane channel writes
//
// One sample is accepted every cycle while o_in_stall is low; a completed block reaches
// o_out_valid after its last sample passes the queue write at acceptance, then the accumulate,
// reciprocal multiply and output registers.
// The input stalls only when the four-entry queue between front and back is full.
// Reset is synchronous and active low; it restores the lane channels and clears all sums
// and counts at once.
module multichannel_block_averager #(
    parameter int SAMPLES = mba_pkg::SAMPLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  mba_pkg::t_in                     i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output mba_pkg::t_out                    o_out_data
);

    logic           push;
    mba_pkg::t_item push_item;
    logic           queue_full;
    logic           pop;
    logic           queue_valid;
    mba_pkg::t_item queue_item;

    mba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .o_push_item  (push_item),
        .i_queue_full (queue_full)
    );

    mba_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_valid     (queue_valid),
        .o_item      (queue_item)
    );

    mba_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
